>>> hdl/mfbd_pkg.sv
`default_nettype none

package mfbd_pkg;

  // Fixed widths of the datapath and of the result fields.
  localparam int ACC_WIDTH       = 24;
  localparam int CNT_WIDTH       = 16;
  localparam int IDX_WIDTH       = 5;
  localparam int LEN_WIDTH       = 6;
  localparam int WEIGHT_WIDTH    = 4;
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int CFG_DATA_WIDTH  = 24;
  localparam int OUT_TDATA_WIDTH = 40;

  // Accumulator saturation limits (24-bit signed).
  localparam int ACC_MAX = 8388607;
  localparam int ACC_MIN = -8388608;

  // Template length and parameter defaults.
  localparam int TEMPLATE_TAPS           = 10;
  localparam int DEF_MAX_SAMPLES_PER_BIT = 20;
  localparam int DEF_SAMPLE_WIDTH        = 16;
  localparam logic [IDX_WIDTH-1:0] SPB_RESET = IDX_WIDTH'(10);

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_MODE            = 2'd0,
    REG_THRESHOLD       = 2'd1,
    REG_SAMPLES_PER_BIT = 2'd2
  } cfg_reg_t;

  // Integration modes.
  localparam logic MODE_RECT     = 1'b0;
  localparam logic MODE_TEMPLATE = 1'b1;

  // Current configuration as seen by the detector.
  typedef struct packed {
    logic                        mode;
    logic signed [ACC_WIDTH-1:0] threshold;
    logic [IDX_WIDTH-1:0]        samples_per_bit;
  } cfg_t;

  // One result of a completed bit period.
  typedef struct packed {
    logic [CNT_WIDTH-1:0] bits_seen;
    logic [CNT_WIDTH-1:0] err_count;
    logic                 bit_error;
    logic                 detected_bit;
  } res_t;

  // Triangular template; positions past the last tap weigh zero.
  function automatic logic [WEIGHT_WIDTH-1:0] tri_weight(input logic [IDX_WIDTH-1:0] idx);
    logic [WEIGHT_WIDTH-1:0] w;
    case (idx)
      5'd1:    w = 4'd6;
      5'd2:    w = 4'd10;
      5'd3:    w = 4'd12;
      5'd4:    w = 4'd15;
      5'd5:    w = 4'd15;
      5'd6:    w = 4'd12;
      5'd7:    w = 4'd10;
      5'd8:    w = 4'd6;
      default: w = 4'd0;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

>>> hdl/mfbd_detect.sv
`default_nettype none

module mfbd_detect
  import mfbd_pkg::*;
#(
  parameter int MAX_SAMPLES_PER_BIT = DEF_MAX_SAMPLES_PER_BIT,
  parameter int SAMPLE_WIDTH        = DEF_SAMPLE_WIDTH
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire cfg_t                           cfg,
  input  wire logic                           step,
  input  wire logic signed [SAMPLE_WIDTH-1:0] sample,
  input  wire logic                           ref_bit,
  output logic                                period_end,
  output res_t                                result
);

  localparam int PROD_WIDTH = SAMPLE_WIDTH + WEIGHT_WIDTH + 1;
  localparam int SUM_WIDTH  = ((ACC_WIDTH > PROD_WIDTH) ? ACC_WIDTH : PROD_WIDTH) + 1;
  localparam logic signed [SUM_WIDTH-1:0] SAT_HI = SUM_WIDTH'(ACC_MAX);
  localparam logic signed [SUM_WIDTH-1:0] SAT_LO = SUM_WIDTH'(ACC_MIN);
  localparam logic [LEN_WIDTH-1:0] MAX_LEN = LEN_WIDTH'(MAX_SAMPLES_PER_BIT);
  localparam logic [LEN_WIDTH-1:0] TAP_LEN = LEN_WIDTH'(TEMPLATE_TAPS);

  logic signed [ACC_WIDTH-1:0] accumulator;
  logic [IDX_WIDTH-1:0]        sample_index;
  logic                        last_decision;
  logic [CNT_WIDTH-1:0]        error_total;
  logic [CNT_WIDTH-1:0]        bit_total;

  logic [LEN_WIDTH-1:0]         period_len;
  logic [LEN_WIDTH-1:0]         spb_ext;
  logic [WEIGHT_WIDTH-1:0]      weight;
  logic signed [PROD_WIDTH-1:0] product;
  logic signed [SUM_WIDTH-1:0]  sum_wide;
  logic signed [ACC_WIDTH-1:0]  sum;
  logic                         decision;
  logic                         err;
  logic [CNT_WIDTH-1:0]         error_total_next;
  logic [CNT_WIDTH-1:0]         bit_total_next;

  // Period length: fixed in template mode, clamped register value in rect mode.
  always_comb begin
    spb_ext = LEN_WIDTH'(cfg.samples_per_bit);
    if (cfg.mode == MODE_TEMPLATE) begin
      period_len = TAP_LEN;
    end else if (spb_ext == '0) begin
      period_len = LEN_WIDTH'(1);
    end else if (spb_ext > MAX_LEN) begin
      period_len = MAX_LEN;
    end else begin
      period_len = spb_ext;
    end
  end

  assign period_end = (LEN_WIDTH'(sample_index) + LEN_WIDTH'(1)) >= period_len;

  // Weighted sample and saturating accumulation.
  assign weight  = (cfg.mode == MODE_TEMPLATE) ? tri_weight(sample_index)
                                               : WEIGHT_WIDTH'(1);
  assign product = $signed({1'b0, weight}) * sample;

  always_comb begin
    sum_wide = SUM_WIDTH'(accumulator) + SUM_WIDTH'(product);
    if (sum_wide > SAT_HI) begin
      sum = ACC_WIDTH'(SAT_HI);
    end else if (sum_wide < SAT_LO) begin
      sum = ACC_WIDTH'(SAT_LO);
    end else begin
      sum = sum_wide[ACC_WIDTH-1:0];
    end
  end

  // Threshold decision; a tie repeats the previous decision.
  always_comb begin
    if (sum > cfg.threshold) begin
      decision = 1'b1;
    end else if (sum < cfg.threshold) begin
      decision = 1'b0;
    end else begin
      decision = last_decision;
    end
    err = decision ^ ref_bit;
    error_total_next = (err && (error_total != '1)) ? error_total + CNT_WIDTH'(1)
                                                    : error_total;
    bit_total_next   = (bit_total != '1) ? bit_total + CNT_WIDTH'(1) : bit_total;
  end

  assign result = '{bits_seen:    bit_total_next,
                    err_count:    error_total_next,
                    bit_error:    err,
                    detected_bit: decision};

  // Period state.
  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator   <= '0;
      sample_index  <= '0;
      last_decision <= 1'b0;
      error_total   <= '0;
      bit_total     <= '0;
    end else if (step) begin
      if (period_end) begin
        accumulator   <= '0;
        sample_index  <= '0;
        last_decision <= decision;
        error_total   <= error_total_next;
        bit_total     <= bit_total_next;
      end else begin
        accumulator  <= sum;
        sample_index <= sample_index + IDX_WIDTH'(1);
      end
    end
  end

  // A completed period leaves a cleared accumulator and index.
  a_period_clears: assert property (@(posedge clk) disable iff (rst)
    step && period_end |=> accumulator == '0 && sample_index == '0)
    else $error("period state not cleared after a decision");

  // Counters move only on a decision.
  a_counts_hold: assert property (@(posedge clk) disable iff (rst)
    !(step && period_end) |=> $stable(bit_total) && $stable(error_total))
    else $error("counters changed without a decision");

  // Errors can never outnumber decided bits.
  a_errors_bounded: assert property (@(posedge clk) disable iff (rst)
    error_total <= bit_total)
    else $error("error count exceeds bit count");

  // Each decision advances the bit count unless it is saturated.
  a_bits_advance: assert property (@(posedge clk) disable iff (rst)
    step && period_end && (bit_total != '1) |=> bit_total == $past(bit_total) + CNT_WIDTH'(1))
    else $error("bit count did not advance on a decision");

endmodule

`default_nettype wire

>>> hdl/matched_filter_bit_detector.sv
`default_nettype none

// Channel   Direction  Transfer               Payload
// s_axis    in         tvalid && tready       tdata: sample, ref_bit
// m_axis    out        tvalid && tready       tdata: detected_bit, bit_error,
//                                             err_count, bits_seen
// cfg       in         cfg_valid && cfg_ready cfg_index, cfg_data
//
// One sample is taken per cycle. A sample lands in an input register, and from
// there its weighted sum, threshold decision and counts are formed, and the
// result register is loaded on the last sample of a bit period.
// The result register then presents that period's result on m_axis.
// Reset (rst, synchronous) clears the period state, counters, configuration and valid flags.
// A sample that ends a period waits only while an untaken result occupies the
// output register; other samples keep flowing. cfg_ready is always high.

module matched_filter_bit_detector
  import mfbd_pkg::*;
#(
  parameter int MAX_SAMPLES_PER_BIT = DEF_MAX_SAMPLES_PER_BIT,
  parameter int SAMPLE_WIDTH        = DEF_SAMPLE_WIDTH
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   s_axis_tvalid,
  output logic                                        s_axis_tready,
  // [SAMPLE_WIDTH-1:0] sample, [SAMPLE_WIDTH] ref_bit, zero fill above
  input  wire logic [((SAMPLE_WIDTH + 8) / 8) * 8 - 1:0] s_axis_tdata,
  output logic                                        m_axis_tvalid,
  input  wire logic                                   m_axis_tready,
  // [0] detected_bit, [1] bit_error, [17:2] err_count, [33:18] bits_seen,
  // [39:34] zero
  output logic [OUT_TDATA_WIDTH-1:0]                  m_axis_tdata,
  input  wire logic                                   cfg_valid,
  output logic                                        cfg_ready,
  input  wire logic [CFG_INDEX_WIDTH-1:0]             cfg_index,
  input  wire logic [CFG_DATA_WIDTH-1:0]              cfg_data
);

  localparam int RES_WIDTH = $bits(res_t);

  cfg_t cfg;

  logic                           in_valid;
  logic signed [SAMPLE_WIDTH-1:0] in_sample;
  logic                           in_ref_bit;
  logic                           step;
  logic                           period_end;
  res_t                           result;
  res_t                           out_result;

  // Configuration registers, written one index per transaction.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode            <= MODE_RECT;
      cfg.threshold       <= '0;
      cfg.samples_per_bit <= SPB_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_MODE:            cfg.mode            <= cfg_data[0];
        REG_THRESHOLD:       cfg.threshold       <= $signed(cfg_data[ACC_WIDTH-1:0]);
        REG_SAMPLES_PER_BIT: cfg.samples_per_bit <= cfg_data[IDX_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // The held sample advances unless it ends a period and the result is blocked.
  assign step          = in_valid && (!period_end || !m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || step;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_sample  <= $signed(s_axis_tdata[SAMPLE_WIDTH-1:0]);
      in_ref_bit <= s_axis_tdata[SAMPLE_WIDTH];
    end
  end

  mfbd_detect #(
    .MAX_SAMPLES_PER_BIT (MAX_SAMPLES_PER_BIT),
    .SAMPLE_WIDTH        (SAMPLE_WIDTH)
  ) u_detect (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .step       (step),
    .sample     (in_sample),
    .ref_bit    (in_ref_bit),
    .period_end (period_end),
    .result     (result)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (step && period_end) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && period_end) begin
      out_result <= result;
    end
  end

  assign m_axis_tdata = {(OUT_TDATA_WIDTH - RES_WIDTH)'(0), out_result};

  // A pending result is never overwritten before it is taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    !(step && period_end && m_axis_tvalid && !m_axis_tready))
    else $error("result register overwritten while stalled");

  // A held sample that cannot advance stays in the input register.
  a_input_held: assert property (@(posedge clk) disable iff (rst)
    in_valid && !step |=> in_valid && $stable(in_sample) && $stable(in_ref_bit))
    else $error("input register lost a waiting sample");

  // Every decision shows up as a valid result on the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    step && period_end |=> m_axis_tvalid)
    else $error("decision did not reach the output");

endmodule

`default_nettype wire

>>> bench/tb_matched_filter_bit_detector.sv
`default_nettype none

module tb_matched_filter_bit_detector;
  import mfbd_pkg::*;

  localparam int IN_WIDTH  = 24;
  localparam int RUN_LIMIT = 1000000;
  // Triangular template, tap 0 in the lowest nibble.
  localparam logic [39:0] TRI_TAPS = {4'd0, 4'd6, 4'd10, 4'd12, 4'd15,
                                      4'd15, 4'd12, 4'd10, 4'd6, 4'd0};

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                       s_axis_tvalid = 1'b0;
  logic                       s_axis_tready;
  logic [IN_WIDTH-1:0]        s_axis_tdata = '0;
  logic                       m_axis_tvalid;
  logic                       m_axis_tready = 1'b0;
  logic [OUT_TDATA_WIDTH-1:0] m_axis_tdata;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = REG_MODE;
  logic [CFG_DATA_WIDTH-1:0]  cfg_data = '0;

  matched_filter_bit_detector DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  // Expected configuration and period state of the detector.
  logic                        cur_mode = MODE_RECT;
  logic signed [ACC_WIDTH-1:0] cur_thr = '0;
  logic [IDX_WIDTH-1:0]        cur_spb = SPB_RESET;
  logic signed [ACC_WIDTH-1:0] acc_sum = '0;
  logic [IDX_WIDTH-1:0]        acc_idx = '0;
  logic                        last_dec = 1'b0;
  logic [CNT_WIDTH-1:0]        err_total = '0;
  logic [CNT_WIDTH-1:0]        bit_total = '0;

  logic [IN_WIDTH-1:0] sample_q[$];
  res_t                expected_bits[$];

  int unsigned samples_queued = 0;
  int unsigned samples_taken = 0;
  int unsigned decisions_checked = 0;
  int unsigned cfg_writes = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned src_gap = 0;
  int unsigned sink_stall = 0;
  bit          src_idle_en = 1'b1;
  bit          sink_idle_en = 1'b1;
  logic        src_hold;

  // Mostly short gaps, a few long ones.
  function automatic int unsigned pick_gap(input bit en);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!en || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  function automatic int unsigned period_len();
    if (cur_mode == MODE_TEMPLATE) return TEMPLATE_TAPS;
    if (cur_spb == 0) return 1;
    if (cur_spb > DEF_MAX_SAMPLES_PER_BIT) return DEF_MAX_SAMPLES_PER_BIT;
    return 32'(cur_spb);
  endfunction

  // Accumulates one sample and queues the decision when its period ends.
  task automatic accumulate_sample(input logic [IN_WIDTH-1:0] word);
    logic signed [15:0] s;
    logic               rb;
    logic               dec;
    longint             sum;
    int unsigned        w;
    res_t               r;
    s = word[15:0];
    rb = word[16];
    w = 1;
    if (cur_mode == MODE_TEMPLATE)
      w = (acc_idx < TEMPLATE_TAPS) ? TRI_TAPS[acc_idx*4 +: 4] : 0;
    sum = longint'(acc_sum) + longint'(w) * longint'(s);
    if (sum > ACC_MAX) sum = ACC_MAX;
    if (sum < ACC_MIN) sum = ACC_MIN;
    if (int'(acc_idx) + 1 < int'(period_len())) begin
      acc_sum = sum[ACC_WIDTH-1:0];
      acc_idx = acc_idx + 1'b1;
    end else begin
      if (sum > longint'(cur_thr)) dec = 1'b1;
      else if (sum < longint'(cur_thr)) dec = 1'b0;
      else dec = last_dec;
      last_dec = dec;
      if (dec != rb && err_total != 16'hFFFF) err_total = err_total + 1'b1;
      if (bit_total != 16'hFFFF) bit_total = bit_total + 1'b1;
      acc_sum = '0;
      acc_idx = '0;
      r.detected_bit = dec;
      r.bit_error = (dec != rb);
      r.err_count = err_total;
      r.bits_seen = bit_total;
      expected_bits.push_back(r);
    end
  endtask

  // One register write; the expected configuration follows at the transaction.
  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_WIDTH-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_MODE:            cur_mode = val[0];
      REG_THRESHOLD:       cur_thr = val;
      REG_SAMPLES_PER_BIT: cur_spb = val[IDX_WIDTH-1:0];
      default: ;
    endcase
    cfg_writes++;
    cfg_valid <= 1'b0;
  endtask

  task automatic push_sample(input logic signed [15:0] s, input logic rb);
    sample_q.push_back({7'd0, rb, s});
    samples_queued++;
  endtask

  // Waits until every sample is taken and every decision checked.
  task automatic wait_drained();
    while (samples_taken != samples_queued || expected_bits.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Bit periods of noisy antipodal samples; some periods are silent or pure noise.
  task automatic gen_periods(input int unsigned n);
    int unsigned plen, pos, kind;
    int          v;
    logic        b;
    plen = period_len();
    pos = 0;
    kind = 0;
    b = 1'b0;
    for (int unsigned i = 0; i < n; i++) begin
      if (pos == 0) begin
        kind = $urandom_range(0, 9);
        b = 1'($urandom_range(0, 1));
      end
      case (kind)
        0: v = 0;
        1: v = int'($urandom_range(0, 65535)) - 32768;
        2: v = b ? 32767 : -32768;
        default: v = (b ? 1 : -1) * int'($urandom_range(0, 4000))
                     + int'($urandom_range(0, 12000)) - 6000;
      endcase
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      push_sample(v[15:0], (pos + 1 == plen) ? b : 1'($urandom_range(0, 1)));
      pos = (pos + 1 == plen) ? 0 : pos + 1;
    end
  endtask

  // Sample source: takes a transaction, then presents the next pending sample.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
    end else begin
      src_hold = s_axis_tvalid && !s_axis_tready;
      if (s_axis_tvalid && s_axis_tready) begin
        accumulate_sample(s_axis_tdata);
        samples_taken++;
      end
      if (!src_hold) begin
        if (src_gap > 0) begin
          src_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (sample_q.size() > 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= sample_q.pop_front();
          src_gap = pick_gap(src_idle_en);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result sink: checks each decision and stalls at random.
  always @(posedge clk) begin
    res_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[$bits(res_t)-1:0];
      if (expected_bits.size() == 0) begin
        $error("unexpected result %h", m_axis_tdata);
        mismatches++;
      end else begin
        want = expected_bits.pop_front();
        decisions_checked++;
        if (got.detected_bit !== want.detected_bit) begin
          $error("detected_bit: expected %0d, got %0d", want.detected_bit, got.detected_bit);
          mismatches++;
        end
        if (got.bit_error !== want.bit_error) begin
          $error("bit_error: expected %0d, got %0d", want.bit_error, got.bit_error);
          mismatches++;
        end
        if (got.err_count !== want.err_count) begin
          $error("err_count: expected %0d, got %0d", want.err_count, got.err_count);
          mismatches++;
        end
        if (got.bits_seen !== want.bits_seen) begin
          $error("bits_seen: expected %0d, got %0d", want.bits_seen, got.bits_seen);
          mismatches++;
        end
      end
    end
    if (sink_stall > 0) begin
      sink_stall--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      sink_stall = pick_gap(sink_idle_en);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= RUN_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int thr;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: full-scale periods of ten samples, then one-sample periods,
    // among them all-zero ones whose sum ties the threshold.
    for (int i = 0; i < 10; i++) push_sample(16'sh7FFF, 1'b0);
    for (int i = 0; i < 10; i++) push_sample(-16'sh8000, 1'b0);
    wait_drained();
    write_reg(REG_SAMPLES_PER_BIT, 24'd1);
    push_sample(16'sd0, 1'b1);
    push_sample(16'sh7FFF, 1'b1);
    push_sample(-16'sh8000, 1'b0);
    push_sample(16'sd0, 1'b1);
    wait_drained();

    // Random phases over a spread of settings; partial periods carry over.
    for (int p = 0; p < 10; p++) begin
      thr = int'($urandom_range(0, 60000)) - 30000;
      case (p)
        0: begin
          write_reg(REG_MODE, CFG_DATA_WIDTH'(MODE_RECT));
          write_reg(REG_SAMPLES_PER_BIT, 24'($urandom_range(2, 19)));
        end
        1: write_reg(REG_MODE, CFG_DATA_WIDTH'(MODE_TEMPLATE));
        2: begin
          write_reg(REG_MODE, CFG_DATA_WIDTH'(MODE_RECT));
          write_reg(REG_SAMPLES_PER_BIT, 24'd20);
          thr = 0;
        end
        3: write_reg(REG_SAMPLES_PER_BIT, 24'd0);
        4: write_reg(REG_SAMPLES_PER_BIT, 24'd31);
        5: begin
          write_reg(REG_MODE, CFG_DATA_WIDTH'(MODE_TEMPLATE));
          thr = ACC_MAX;
        end
        6: begin
          write_reg(REG_MODE, CFG_DATA_WIDTH'(MODE_RECT));
          write_reg(REG_SAMPLES_PER_BIT, 24'd1);
          thr = ACC_MIN;
        end
        7: begin
          write_reg(REG_MODE, CFG_DATA_WIDTH'(MODE_TEMPLATE));
          write_reg(REG_SAMPLES_PER_BIT, 24'($urandom_range(21, 31)));
          thr = 0;
        end
        default: begin
          write_reg(REG_MODE, 24'($urandom_range(0, 1)));
          write_reg(REG_SAMPLES_PER_BIT, 24'($urandom_range(0, 31)));
        end
      endcase
      write_reg(REG_THRESHOLD, thr[CFG_DATA_WIDTH-1:0]);
      src_idle_en = ($urandom_range(0, 3) != 0);
      sink_idle_en = ($urandom_range(0, 3) != 0);
      gen_periods($urandom_range(55, 85));
      wait_drained();
    end

    // Closing phase: one-sample periods, each ending in a decision.
    write_reg(REG_MODE, CFG_DATA_WIDTH'(MODE_RECT));
    write_reg(REG_SAMPLES_PER_BIT, 24'd1);
    write_reg(REG_THRESHOLD, 24'd0);
    src_idle_en = 1'b1;
    sink_idle_en = 1'b1;
    gen_periods(40);
    wait_drained();
    repeat (10) @(posedge clk);

    $display("Sent %0d samples and checked %0d bit decisions across %0d register writes,",
             samples_taken, decisions_checked, cfg_writes);
    $display("covering both modes, out-of-range period lengths and tied sums.");
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
